[rtl/core/gtor_pkg.sv]
// ----------------------------------------------------------------------------
// gtor_pkg
// Shared types and constants for the g-code target and offset resolver.
// ----------------------------------------------------------------------------
package gtor_pkg;

    localparam int AXES    = 4;
    localparam int VALUE_W = 32;
    localparam int MASK_W  = 4;

    // slave tdata: axis_mask, four commanded words, four current positions
    localparam int S_MASK_LSB    = 0;
    localparam int S_VALUE_LSB   = S_MASK_LSB + MASK_W;
    localparam int S_CURRENT_LSB = S_VALUE_LSB + AXES * VALUE_W;
    localparam int S_USED_W      = S_CURRENT_LSB + AXES * VALUE_W;
    localparam int S_TDATA_W     = ((S_USED_W + 7) / 8) * 8;
    localparam int S_TUSER_W     = 4;

    // master tdata: four targets, then four summed offsets
    localparam int M_TDATA_W = 2 * AXES * VALUE_W;

    // inch scaling: 25.4 * m = 25 * m + floor(2 * (m + 1) / 5) after rounding
    localparam int             INCH_WHOLE = 25;
    localparam int             SCALE_W    = 38;
    localparam int             DIV5_W     = 33;
    localparam int             DIV5_SHIFT = 35;
    localparam logic [DIV5_W-1:0] DIV5_RECIP = 33'h1_9999_999A;

    typedef enum logic [1:0] {
        OP_RESOLVE    = 2'd0,
        OP_SET_TEMP   = 2'd1,
        OP_SET_WORK   = 2'd2,
        OP_CLEAR_TEMP = 2'd3
    } t_opcode;

    // slave tuser, lowest bits first: opcode, inch_mode, absolute_mode
    typedef struct packed {
        logic    absolute_mode;
        logic    inch_mode;
        t_opcode opcode;
    } t_s_user;

    typedef struct packed {
        t_opcode opcode;
        logic    sel;
        logic    mask_empty;
        logic    inch;
        logic    absolute;
    } t_axis_ctrl;

endpackage

[rtl/core/gtor_axis.sv]
// ----------------------------------------------------------------------------
// gtor_axis
// Per-axis datapath: inch scaling, target resolution, offset updates and
// the saturated offset sum.
// ----------------------------------------------------------------------------
module gtor_axis #(
    parameter int POSITION_WIDTH = 32
) (
    input  gtor_pkg::t_axis_ctrl                     i_ctrl,
    input  logic signed [gtor_pkg::VALUE_W-1:0]      i_value,
    input  logic signed [gtor_pkg::VALUE_W-1:0]      i_current,
    input  logic signed [POSITION_WIDTH-1:0]         i_temp,
    input  logic signed [POSITION_WIDTH-1:0]         i_work,
    output logic signed [POSITION_WIDTH-1:0]         o_temp_next,
    output logic signed [POSITION_WIDTH-1:0]         o_work_next,
    output logic signed [gtor_pkg::VALUE_W-1:0]      o_target,
    output logic signed [gtor_pkg::VALUE_W-1:0]      o_offset
);
    import gtor_pkg::*;

    localparam int WW = ((POSITION_WIDTH > SCALE_W) ? POSITION_WIDTH : SCALE_W) + 2;

    function automatic logic signed [POSITION_WIDTH-1:0] sat(input logic signed [WW-1:0] v);
        if ((&v[WW-1:POSITION_WIDTH-1]) || !(|v[WW-1:POSITION_WIDTH-1])) begin
            sat = v[POSITION_WIDTH-1:0];
        end else begin
            sat = {v[WW-1], {(POSITION_WIDTH-1){~v[WW-1]}}};
        end
    endfunction

    logic                              neg;
    logic [VALUE_W-1:0]                mag;
    logic [VALUE_W-1:0]                mag_inc;
    logic [DIV5_W-1:0]                 dividend;
    logic [2*DIV5_W-1:0]               prod;
    logic [2*DIV5_W-DIV5_SHIFT-1:0]    quot;
    logic [SCALE_W-2:0]                mag_scaled;
    logic signed [SCALE_W-1:0]         scaled;
    logic signed [WW-1:0]              v_in;
    logic signed [POSITION_WIDTH-1:0]  v_sat;
    logic signed [WW-1:0]              abs_sum;
    logic signed [WW-1:0]              rel_sum;
    logic signed [POSITION_WIDTH-1:0]  temp_set;
    logic signed [POSITION_WIDTH-1:0]  work_set;

    // magnitude, rounded to nearest with ties away from zero
    assign neg        = i_value[VALUE_W-1];
    assign mag        = neg ? (~i_value + 32'd1) : i_value;
    assign mag_inc    = mag + 32'd1;
    assign dividend   = {mag_inc, 1'b0};
    assign prod       = (2*DIV5_W)'(dividend) * (2*DIV5_W)'(DIV5_RECIP);
    assign quot       = prod[2*DIV5_W-1:DIV5_SHIFT];
    assign mag_scaled = (SCALE_W-1)'(mag) * (SCALE_W-1)'(INCH_WHOLE)
                      + (SCALE_W-1)'(quot);
    assign scaled     = neg ? -$signed({1'b0, mag_scaled}) : $signed({1'b0, mag_scaled});

    assign v_in     = i_ctrl.inch ? WW'(scaled) : WW'(i_value);
    assign v_sat    = sat(v_in);
    assign abs_sum  = WW'(v_sat) + WW'(i_temp) + WW'(i_work);
    assign rel_sum  = WW'(i_current) + WW'(v_sat);
    assign temp_set = sat(WW'(i_current) - WW'(i_value));
    assign work_set = sat(WW'(i_value));

    always_comb begin
        o_temp_next = i_temp;
        o_work_next = i_work;
        o_target    = i_current;
        unique case (i_ctrl.opcode)
            OP_RESOLVE: begin
                if (i_ctrl.sel) begin
                    o_target = i_ctrl.absolute ? VALUE_W'(sat(abs_sum))
                                               : VALUE_W'(sat(rel_sum));
                end
            end
            OP_SET_TEMP: begin
                if (i_ctrl.mask_empty) begin
                    o_temp_next = '0;
                end else if (i_ctrl.sel) begin
                    o_temp_next = temp_set;
                end
            end
            OP_SET_WORK: begin
                if (i_ctrl.sel) begin
                    o_work_next = work_set;
                end
            end
            OP_CLEAR_TEMP: begin
                o_temp_next = '0;
            end
            default: begin
                o_temp_next = i_temp;
            end
        endcase
    end

    // offsets reported after this beat's update
    assign o_offset = VALUE_W'(sat(WW'(o_temp_next) + WW'(o_work_next)));

endmodule

[rtl/core/gcode_target_offset_resolver_unit.sv]
// ----------------------------------------------------------------------------
// gcode_target_offset_resolver_unit
// Four-axis g-code target resolver with temporary and work offsets.
// ----------------------------------------------------------------------------
// path: slave beat to master beat through the input register and the result
//   register, one add-and-saturate datapath per axis in between
// throughput: one beat per cycle while the master side takes beats; offsets
//   update as a beat leaves the input register, so the next beat sees them at once
// reset: synchronous, clears both valid flags and all offsets to zero
module gcode_target_offset_resolver_unit #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // axis_mask, x/y/z/c_value, current_x/y/z/c, zero pad
    input  logic [gtor_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // opcode, inch_mode, absolute_mode
    input  logic [gtor_pkg::S_TUSER_W-1:0]     i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // target_x/y/z/c, offset_x/y/z/c
    output logic [gtor_pkg::M_TDATA_W-1:0]     o_m_tdata
);
    import gtor_pkg::*;

    logic                              r_in_vld;
    logic [S_USED_W-1:0]               r_in_data;
    t_s_user                           r_in_user;
    logic                              r_out_vld;
    logic [M_TDATA_W-1:0]              r_out_data;
    logic [M_TDATA_W-1:0]              n_out_data;
    logic signed [POSITION_WIDTH-1:0]  r_temp [AXES];
    logic signed [POSITION_WIDTH-1:0]  r_work [AXES];
    logic signed [POSITION_WIDTH-1:0]  n_temp [AXES];
    logic signed [POSITION_WIDTH-1:0]  n_work [AXES];
    logic                              adv;
    logic                              s_acc;
    logic                              mask_empty;

    assign adv        = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || adv;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign mask_empty = (r_in_data[S_MASK_LSB +: MASK_W] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_data <= i_s_tdata[S_USED_W-1:0];
            r_in_user <= t_s_user'(i_s_tuser);
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        t_axis_ctrl ctrl;

        assign ctrl.opcode     = r_in_user.opcode;
        assign ctrl.sel        = r_in_data[S_MASK_LSB + g];
        assign ctrl.mask_empty = mask_empty;
        assign ctrl.inch       = r_in_user.inch_mode;
        assign ctrl.absolute   = r_in_user.absolute_mode;

        gtor_axis #(
            .POSITION_WIDTH (POSITION_WIDTH)
        ) u_axis (
            .i_ctrl      (ctrl),
            .i_value     ($signed(r_in_data[S_VALUE_LSB + g*VALUE_W +: VALUE_W])),
            .i_current   ($signed(r_in_data[S_CURRENT_LSB + g*VALUE_W +: VALUE_W])),
            .i_temp      (r_temp[g]),
            .i_work      (r_work[g]),
            .o_temp_next (n_temp[g]),
            .o_work_next (n_work[g]),
            .o_target    (n_out_data[g*VALUE_W +: VALUE_W]),
            .o_offset    (n_out_data[(AXES+g)*VALUE_W +: VALUE_W])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_temp[g] <= '0;
                r_work[g] <= '0;
            end else if (adv) begin
                r_temp[g] <= n_temp[g];
                r_work[g] <= n_work[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

[rtl/core/gtor_chk.sv]
// ----------------------------------------------------------------------------
// gtor_chk
// Port-level checks for the g-code target and offset resolver.
// ----------------------------------------------------------------------------
module gtor_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [gtor_pkg::M_TDATA_W-1:0]     o_m_tdata
);

    // a stalled result beat holds
    a_m_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled master beat changed");

    // valid only drops after a handshake
    a_m_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_m_tvalid) |-> $past(i_m_tready))
        else $error("master valid dropped without handshake");

    // with the result register empty the input side never stalls
    a_s_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("slave stalled with empty result register");

    // a beat taken into an empty result path reaches the master side through the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid |=> ##1 o_m_tvalid)
        else $error("result beat missing after accepted beat");

endmodule

bind gcode_target_offset_resolver_unit gtor_chk u_gtor_chk (.*);
